FILE: hdl/tem_pkg.sv
// ----------------------------------------------------------------------------
// tem_pkg
// Shared types, codes and defaults for the timer expiry queue.
// ----------------------------------------------------------------------------
package tem_pkg;

    localparam int NUM_TIMERS_DEF = 32;
    localparam int ID_BITS_DEF    = 32;
    localparam int TIME_BITS_DEF  = 48;

    localparam int ACTION_W = 2;
    localparam int KIND_W   = 2;
    localparam int PID_W    = 32;
    localparam int PTIME_W  = 48;
    localparam int PCNT_W   = 6;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POP    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic accept;        // latch a new transaction and apply its table effect
        logic scan_start;    // begin a pass over all slots
        logic cancel_clear;  // drop the slot found by the cancel pass
        logic fire;          // drop the earliest slot and count it
        logic emit;          // load the output register
        logic emit_fire;     // the loaded result is a fired timer
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic                scan_done;
        logic [ACTION_W-1:0] op;
        logic                best_expired;
        logic                out_free;
    } t_sts;

endpackage

FILE: hdl/tem_ram.sv
// ----------------------------------------------------------------------------
// tem_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module tem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tem_ctrl.sv
// ----------------------------------------------------------------------------
// tem_ctrl
// Sequencer for the timer queue: scan passes, firing loop and result hand-off.
// ----------------------------------------------------------------------------
module tem_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  tem_pkg::t_sts i_sts,
    output tem_pkg::t_cmd o_cmd
);
    import tem_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_cancel_pend, n_cancel_pend;
    logic       r_fire_pend, n_fire_pend;
    t_cmd       cmd;

    always_comb begin
        n_state       = r_state;
        n_cancel_pend = r_cancel_pend;
        n_fire_pend   = r_fire_pend;
        cmd           = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.accept     = 1'b1;
                    cmd.scan_start = 1'b1;
                    n_cancel_pend  = 1'b0;
                    n_fire_pend    = 1'b0;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.op == ACT_CANCEL && !r_cancel_pend) begin
                    cmd.cancel_clear = 1'b1;
                    cmd.scan_start   = 1'b1;
                    n_cancel_pend    = 1'b1;
                    n_state          = S_SCAN;
                end else if (r_fire_pend) begin
                    n_state = S_EMIT;
                end else if (i_sts.op == ACT_POP && i_sts.best_expired) begin
                    cmd.fire       = 1'b1;
                    cmd.scan_start = 1'b1;
                    n_fire_pend    = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_fire = r_fire_pend;
                    n_fire_pend   = 1'b0;
                    n_state       = r_fire_pend ? S_DECIDE : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cancel_pend <= 1'b0;
            r_fire_pend   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cancel_pend <= n_cancel_pend;
            r_fire_pend   <= n_fire_pend;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_cmd   = cmd;

endmodule

FILE: hdl/tem_dp.sv
// ----------------------------------------------------------------------------
// tem_dp
// Slot table, scan unit and output register of the timer queue.
// ----------------------------------------------------------------------------
module tem_dp #(
    parameter int NUM_TIMERS = tem_pkg::NUM_TIMERS_DEF,
    parameter int ID_BITS    = tem_pkg::ID_BITS_DEF,
    parameter int TIME_BITS  = tem_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  tem_pkg::t_cmd                i_cmd,
    output tem_pkg::t_sts                o_sts,
    input  logic [tem_pkg::ACTION_W-1:0] i_action,
    input  logic [tem_pkg::PTIME_W-1:0]  i_time_ms,
    input  logic [tem_pkg::PID_W-1:0]    i_cancel_id,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [tem_pkg::KIND_W-1:0]   o_result_kind,
    output logic [tem_pkg::PID_W-1:0]    o_result_id,
    output logic [tem_pkg::PCNT_W-1:0]   o_fire_total,
    output logic [tem_pkg::PCNT_W-1:0]   o_active_count,
    output logic                         o_next_valid,
    output logic [tem_pkg::PTIME_W-1:0]  o_next_expiration,
    output logic                         o_last
);
    import tem_pkg::*;

    localparam int SW = $clog2(NUM_TIMERS);
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int DW = ID_BITS + TIME_BITS;
    localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_TIMERS - 1);

    logic [NUM_TIMERS-1:0] r_valid;
    logic [ID_BITS-1:0]    r_next_id;
    logic [CW-1:0]         r_live;
    logic [ACTION_W-1:0]   r_op;
    logic [TIME_BITS-1:0]  r_time;
    logic [ID_BITS-1:0]    r_cid;
    logic                  r_refused;
    logic [ID_BITS-1:0]    r_add_id;
    logic [CW-1:0]         r_fired_cnt;
    logic [ID_BITS-1:0]    r_fired_id;

    logic                  r_scan_on;
    logic [SW-1:0]         r_idx;
    logic                  r_rd_on;
    logic [SW-1:0]         r_rd_idx;
    logic                  r_best_valid;
    logic [TIME_BITS-1:0]  r_best_dl;
    logic [ID_BITS-1:0]    r_best_id;
    logic [SW-1:0]         r_best_slot;
    logic                  r_match_found;
    logic [SW-1:0]         r_match_slot;

    logic                  r_o_valid;
    logic [KIND_W-1:0]     r_o_kind;
    logic [PID_W-1:0]      r_o_id;
    logic [PCNT_W-1:0]     r_o_fired;
    logic [PCNT_W-1:0]     r_o_active;
    logic                  r_o_next_valid;
    logic [PTIME_W-1:0]    r_o_next_exp;
    logic                  r_o_last;

    logic [63:0]           in_time64, in_cid64, best_dl64, id64;
    logic [TIME_BITS-1:0]  in_time;
    logic [ID_BITS-1:0]    in_cid;
    logic                  full;
    logic [SW-1:0]         free_slot;
    logic                  we;
    logic [DW-1:0]         rdata;
    logic [TIME_BITS-1:0]  rd_dl;
    logic [ID_BITS-1:0]    rd_id;
    logic                  rd_ok;
    logic                  better;
    logic                  out_free;
    logic [ID_BITS-1:0]    emit_id;

    assign in_time64 = 64'(i_time_ms);
    assign in_cid64  = 64'(i_cancel_id);
    assign in_time   = in_time64[TIME_BITS-1:0];
    assign in_cid    = in_cid64[ID_BITS-1:0];

    // lowest free slot
    always_comb begin
        free_slot = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = SW'(i);
            end
        end
    end
    assign full = &r_valid;
    assign we   = i_cmd.accept && (i_action == ACT_ADD) && !full;

    tem_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_TIMERS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (free_slot),
        .i_wdata ({r_next_id, in_time}),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    assign rd_dl  = rdata[TIME_BITS-1:0];
    assign rd_id  = rdata[DW-1:TIME_BITS];
    assign rd_ok  = r_rd_on && r_valid[r_rd_idx];
    assign better = !r_best_valid || (rd_dl < r_best_dl) ||
                    ((rd_dl == r_best_dl) && (rd_id < r_best_id));

    assign out_free = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_next_id <= ID_BITS'(1);
            r_live    <= '0;
            r_scan_on <= 1'b0;
            r_rd_on   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // table effect of a new transaction
            if (i_cmd.accept) begin
                r_op        <= i_action;
                r_time      <= in_time;
                r_cid       <= in_cid;
                r_fired_cnt <= '0;
                r_refused   <= full;
                r_add_id    <= r_next_id;
                if (we) begin
                    r_valid[free_slot] <= 1'b1;
                    r_live             <= r_live + CW'(1);
                    r_next_id          <= r_next_id + ID_BITS'(1);
                end
                if (i_action == ACT_CLEAR) begin
                    r_valid <= '0;
                    r_live  <= '0;
                end
            end
            if (i_cmd.cancel_clear && r_match_found) begin
                r_valid[r_match_slot] <= 1'b0;
                r_live                <= r_live - CW'(1);
            end
            if (i_cmd.fire) begin
                r_valid[r_best_slot] <= 1'b0;
                r_live               <= r_live - CW'(1);
                r_fired_cnt          <= r_fired_cnt + CW'(1);
                r_fired_id           <= r_best_id;
            end

            // scan address sequencer
            if (i_cmd.scan_start) begin
                r_scan_on <= 1'b1;
                r_idx     <= '0;
            end else if (r_scan_on) begin
                if (r_idx == LAST_SLOT) begin
                    r_scan_on <= 1'b0;
                end else begin
                    r_idx <= r_idx + SW'(1);
                end
            end
            r_rd_on  <= r_scan_on && !i_cmd.scan_start;
            r_rd_idx <= r_idx;

            // output register
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // running minimum and cancel match over the read stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid  <= 1'b0;
            r_match_found <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_best_valid  <= 1'b0;
            r_match_found <= 1'b0;
        end else if (rd_ok) begin
            if (better) begin
                r_best_valid <= 1'b1;
                r_best_dl    <= rd_dl;
                r_best_id    <= rd_id;
                r_best_slot  <= r_rd_idx;
            end
            if (!r_match_found && rd_id == r_cid) begin
                r_match_found <= 1'b1;
                r_match_slot  <= r_rd_idx;
            end
        end
    end

    assign best_dl64 = 64'(r_best_dl);

    always_comb begin
        if (i_cmd.emit_fire) begin
            emit_id = r_fired_id;
        end else if (r_op == ACT_ADD && !r_refused) begin
            emit_id = r_add_id;
        end else begin
            emit_id = '0;
        end
    end
    assign id64 = 64'(emit_id);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (i_cmd.emit_fire) begin
                r_o_kind <= KIND_FIRED;
            end else if (r_op == ACT_ADD && r_refused) begin
                r_o_kind <= KIND_REFUSED;
            end else begin
                r_o_kind <= KIND_ACK;
            end
            r_o_id         <= id64[PID_W-1:0];
            r_o_fired      <= (i_cmd.emit_fire || r_op == ACT_POP) ?
                              PCNT_W'(r_fired_cnt) : '0;
            r_o_active     <= PCNT_W'(r_live);
            r_o_next_valid <= r_best_valid;
            r_o_next_exp   <= r_best_valid ? best_dl64[PTIME_W-1:0] : '0;
            r_o_last       <= !i_cmd.emit_fire;
        end
    end

    assign o_sts.scan_done    = r_rd_on && (r_rd_idx == LAST_SLOT);
    assign o_sts.op           = r_op;
    assign o_sts.best_expired = r_best_valid && (r_best_dl <= r_time);
    assign o_sts.out_free     = out_free;

    assign o_valid           = r_o_valid;
    assign o_result_kind     = r_o_kind;
    assign o_result_id       = r_o_id;
    assign o_fire_total      = r_o_fired;
    assign o_active_count    = r_o_active;
    assign o_next_valid      = r_o_next_valid;
    assign o_next_expiration = r_o_next_exp;
    assign o_last            = r_o_last;

endmodule

FILE: hdl/timer_expiry_queue.sv
// ----------------------------------------------------------------------------
// timer_expiry_queue
// Table of pending timers with add, cancel, pop-expired and clear actions.
// ----------------------------------------------------------------------------
// The block holds up to NUM_TIMERS timers in a slot RAM with one valid flop
// per slot. Every result reports the live count and the earliest pending
// expiration, which a full pass over the slot RAM finds: one slot is read per
// cycle, and the single RAM read port sets the rate. An add, a clear or a pop
// with nothing expired makes one pass; a cancel needs a second pass after the
// slot is dropped; a pop makes one more pass per fired timer. A receiver that
// holds off a waiting result stalls the sequence. Results leave through an
// output register, so the last result of one transaction may wait there
// while the next transaction is accepted. No clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
module timer_expiry_queue #(
    parameter int NUM_TIMERS = tem_pkg::NUM_TIMERS_DEF,
    parameter int ID_BITS    = tem_pkg::ID_BITS_DEF,
    parameter int TIME_BITS  = tem_pkg::TIME_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tem_pkg::ACTION_W-1:0] i_action,
    input  logic [tem_pkg::PTIME_W-1:0]  i_time_ms,
    input  logic [tem_pkg::PID_W-1:0]    i_cancel_id,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [tem_pkg::KIND_W-1:0]   o_result_kind,
    output logic [tem_pkg::PID_W-1:0]    o_result_id,
    output logic [tem_pkg::PCNT_W-1:0]   o_fire_total,
    output logic [tem_pkg::PCNT_W-1:0]   o_active_count,
    output logic                         o_next_valid,
    output logic [tem_pkg::PTIME_W-1:0]  o_next_expiration,
    output logic                         o_last
);
    import tem_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequence scans, firing and result hand-off
    tem_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // hold the slot table, run the scan and drive the result fields
    tem_dp #(
        .NUM_TIMERS (NUM_TIMERS),
        .ID_BITS    (ID_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_action          (i_action),
        .i_time_ms         (i_time_ms),
        .i_cancel_id       (i_cancel_id),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_result_kind     (o_result_kind),
        .o_result_id       (o_result_id),
        .o_fire_total      (o_fire_total),
        .o_active_count    (o_active_count),
        .o_next_valid      (o_next_valid),
        .o_next_expiration (o_next_expiration),
        .o_last            (o_last)
    );

endmodule
